@@ rtl/core/bpa_pkg.sv @@
// bpa_pkg: shared types and constants for the bitmap page allocator
// holds operation and status codes, field widths and the sequencer state type
// no dependencies
package bpa_pkg;

  // field widths
  localparam int PAGE_W    = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BELOW = 2'd1;

  // configuration reset values
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST    = 13'd4096;
  localparam logic [CFG_W-1:0] RESERVED_BELOW_RST = 13'd256;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_ADDR  = 6'b001000,
    S_CHECK = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

endpackage

@@ rtl/core/bitmap_page_allocator.sv @@
// bitmap_page_allocator: page allocator over a used-bit bitmap in one synchronous memory
// depends on bpa_pkg for codes, widths and the sequencer state type
//
// One request is in flight at a time. Free, reserve and query pass from transfer through
// S_DIV, S_ADDR and S_CHECK to S_RESP, or straight to S_RESP when the page is ignored;
// allocate tries the last-freed hint when it is usable, answers no-free directly when the
// scan range is empty, and otherwise scans bitmap words from reserved_below up to the page
// limit (about 120 words at reset values); a stale hint falls back to that scan.
// The scan rate is set by the single memory port, one word per cycle. After reset a
// clearing pass writes every bitmap word to zero, one word a cycle (128 words with the
// default parameters), and no request is taken until it ends; configuration writes are
// taken at any time but must only be issued while the block is idle. A finished result
// sits in an output register, so the next request may be taken while it waits.
module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bpa_pkg::S_DATA_W-1:0]  s_tdata,   // operation[1:0], page[13:2], zero pad
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bpa_pkg::M_DATA_W-1:0]  m_tdata,   // result_page[11:0], page_used[12],
                                                   // status[14:13], zero pad
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_data
);
  import bpa_pkg::*;

  // geometry: only pages below 8192 are ever reachable through the 13-bit limit
  localparam int MEM_PAGES = (MAX_PAGES < 8192) ? MAX_PAGES : 8192;
  localparam int LIM_CAP   = (MAX_PAGES < 8192) ? MAX_PAGES : 8191;
  localparam int MEM_WORDS = (MEM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int PB        = CFG_W + 1;
  // page to word division by reciprocal multiply, exact for 13-bit pages
  localparam int DSH       = CFG_W + BW;
  localparam int RECIP     = ((1 << DSH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = 2 * CFG_W + 2;

  // bitmap memory
  logic [WORD_BITS-1:0] map_mem [MEM_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  // control and configuration registers
  state_t               state;
  logic [AW-1:0]        clr_cnt;
  logic [CFG_W-1:0]     total_pages;
  logic [CFG_W-1:0]     reserved_below;
  logic [PAGE_W-1:0]    freed_hint;

  // request context
  op_t                  op_r;
  logic                 hint_try;
  logic [CFG_W-1:0]     tpg;
  logic [AW-1:0]        word_r;
  logic [PB-1:0]        base_r;
  logic [BW-1:0]        bit_r;

  // pending result and output register
  logic [PAGE_W-1:0]    res_page;
  logic                 res_used;
  status_t              res_status;
  logic [PAGE_W-1:0]    out_page;
  logic                 out_used;
  status_t              out_status;
  logic                 out_valid;

  // combinational helpers
  logic [CFG_W-1:0]     lim;
  logic                 hint_ok;
  logic                 scan_empty;
  op_t                  in_op;
  logic [PAGE_W-1:0]    in_pg;
  logic [PW-1:0]        prod;
  logic [PB-1:0]        word_base;
  logic [PB-1:0]        span;
  logic [PB-1:0]        next_base;
  logic                 more;
  logic [WORD_BITS-1:0] cand;
  logic                 find_any;
  logic [BW-1:0]        find_idx;
  logic                 sel_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] find_mask;

  // limits and request decode
  always_comb begin
    lim        = (total_pages < CFG_W'(LIM_CAP)) ? total_pages : CFG_W'(LIM_CAP);
    hint_ok    = (freed_hint != '0) && ({1'b0, freed_hint} < lim);
    scan_empty = (reserved_below >= lim);
    in_op      = op_t'(s_tdata[1:0]);
    in_pg      = s_tdata[PAGE_W+1:2];
  end

  // word index and word base of the target page
  always_comb begin
    prod      = PW'(tpg) * PW'(RECIP);
    word_base = PB'(word_r) * PB'(WORD_BITS);
  end

  // search of the current word for the lowest free page in range
  always_comb begin
    span      = {1'b0, lim} - base_r;
    next_base = base_r + PB'(WORD_BITS);
    more      = next_base < {1'b0, lim};
    for (int b = 0; b < WORD_BITS; b++) begin
      cand[b] = !rdata[b] && (BW'(b) >= bit_r) && (PB'(b) < span);
    end
    find_any = |cand;
    find_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        find_idx = BW'(b);
      end
    end
    sel_bit   = rdata[bit_r];
    bit_mask  = WORD_BITS'(1) << bit_r;
    find_mask = WORD_BITS'(1) << find_idx;
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = word_r;
    mem_wdata = rdata;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_ADDR: begin
        mem_re = 1'b1;
      end
      S_CHECK: begin
        case (op_r)
          OP_ALLOC: begin
            if (hint_try) begin
              mem_we    = !sel_bit;
              mem_wdata = rdata | bit_mask;
            end else if (find_any) begin
              mem_we    = 1'b1;
              mem_wdata = rdata | find_mask;
            end else if (more) begin
              mem_re   = 1'b1;
              mem_addr = word_r + AW'(1);
            end
          end
          OP_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = rdata & ~bit_mask;
          end
          OP_RESERVE: begin
            mem_we    = 1'b1;
            mem_wdata = rdata | bit_mask;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // bitmap storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= map_mem[mem_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages    <= TOTAL_PAGES_RST;
      reserved_below <= RESERVED_BELOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOTAL_PAGES:    total_pages    <= cfg_data;
        REG_RESERVED_BELOW: reserved_below <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      freed_hint <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output drains here unless the response state reloads it this cycle
      if (out_valid && m_tready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_r       <= in_op;
            res_page   <= in_pg;
            res_used   <= 1'b0;
            res_status <= ST_OK;
            if (in_op == OP_ALLOC) begin
              freed_hint <= '0;
              if (hint_ok) begin
                tpg      <= {1'b0, freed_hint};
                hint_try <= 1'b1;
                state    <= S_DIV;
              end else if (scan_empty) begin
                res_status <= ST_NO_FREE;
                state      <= S_RESP;
              end else begin
                tpg      <= reserved_below;
                hint_try <= 1'b0;
                state    <= S_DIV;
              end
            end else if (({1'b0, in_pg} >= lim) || (in_op == OP_FREE && in_pg == '0)) begin
              res_status <= ST_RANGE;
              state      <= S_RESP;
            end else begin
              if (in_op == OP_FREE) begin
                freed_hint <= in_pg;
              end
              tpg      <= {1'b0, in_pg};
              hint_try <= 1'b0;
              state    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          word_r <= prod[DSH +: AW];
          state  <= S_ADDR;
        end
        S_ADDR: begin
          base_r <= word_base;
          bit_r  <= BW'(PB'(tpg) - word_base);
          state  <= S_CHECK;
        end
        S_CHECK: begin
          case (op_r)
            OP_ALLOC: begin
              if (hint_try) begin
                if (!sel_bit) begin
                  res_page <= tpg[PAGE_W-1:0];
                  res_used <= 1'b1;
                  state    <= S_RESP;
                end else if (scan_empty) begin
                  res_status <= ST_NO_FREE;
                  state      <= S_RESP;
                end else begin
                  // stale hint: fall back to the scan
                  tpg      <= reserved_below;
                  hint_try <= 1'b0;
                  state    <= S_DIV;
                end
              end else if (find_any) begin
                res_page <= PAGE_W'(base_r + PB'(find_idx));
                res_used <= 1'b1;
                state    <= S_RESP;
              end else if (more) begin
                word_r <= word_r + AW'(1);
                base_r <= next_base;
                bit_r  <= '0;
              end else begin
                res_status <= ST_NO_FREE;
                state      <= S_RESP;
              end
            end
            OP_RESERVE: begin
              res_used <= 1'b1;
              state    <= S_RESP;
            end
            OP_QUERY: begin
              res_used <= sel_bit;
              state    <= S_RESP;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_RESP: begin
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_page   <= res_page;
            out_used   <= res_used;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_status, out_used, out_page};

  // one request in flight: a transfer closes the request side for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  // the single bitmap port never reads and writes together
  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  // a failed allocation never reports the page as used
  a_no_free_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_NO_FREE) |-> !out_used)
    else $error("no-free result marked used");

  // no request is taken and no bitmap read is made during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready && !mem_re)
    else $error("request or read during clearing pass");

endmodule

@@ bench/bitmap_page_allocator_test.sv @@
// bitmap_page_allocator_test: self-checking bench for the bitmap page allocator
// drives allocate/free/reserve/query transfers, predicts each result and compares it
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 100ps

module bitmap_page_allocator_test;
  import bpa_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [11:0] page;
  } page_request_t;

  typedef struct packed {
    logic [11:0] page;
    logic        used;
    status_t     status;
  } page_result_t;

  localparam int MAP_PAGES   = 4096;
  localparam int DRAIN_WAIT  = 150;
  localparam int NUM_PHASES  = 8;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;    // operation[1:0], page[13:2], zero pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;    // result_page[11:0], page_used[12], status[14:13]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  logic         used_map [MAP_PAGES];
  logic [11:0]  last_freed;
  int           total_pages_reg;
  int           reserved_below_reg;

  page_request_t pending_requests [$];
  page_result_t  expected_results [$];
  page_request_t drive_req;
  page_result_t  want_result;
  logic          req_taken;
  int            requests_queued;
  int            requests_taken;
  int            error_count;
  int            send_idle_pct;
  int            recv_stall_pct;

  // phase settings: register values, idle and stall odds, random item count
  int phase_total    [NUM_PHASES] = '{4096, 8191, 1,  48, 4096, 8191, 100, 4096};
  int phase_reserved [NUM_PHASES] = '{256,  0,    0,  16, 4096, 8191, 30,  4064};
  int phase_idle     [NUM_PHASES] = '{0,    54,   0,  11, 0,    54,   0,   11};
  int phase_stall    [NUM_PHASES] = '{0,    0,    54, 11, 0,    0,    54,  11};
  int phase_items    [NUM_PHASES] = '{60,   60,   40, 80, 40,   30,   80,  60};

  bitmap_page_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // expected outcome of one request, updating the shadow bitmap and hint
  function automatic page_result_t predict_page_op(page_request_t req);
    page_result_t res;
    int           limit;
    int           hint;
    int           p;
    logic         found;
    limit = (total_pages_reg < MAP_PAGES) ? total_pages_reg : MAP_PAGES;
    res.page   = req.page;
    res.used   = 1'b0;
    res.status = ST_OK;
    if (req.op == OP_ALLOC) begin
      hint = int'(last_freed);
      found = 1'b0;
      last_freed = '0;
      if (hint != 0 && hint < limit && !used_map[hint]) begin
        res.page = hint[11:0];
        found = 1'b1;
      end else begin
        for (p = reserved_below_reg; p < limit && !found; p++) begin
          if (!used_map[p]) begin
            res.page = p[11:0];
            found = 1'b1;
          end
        end
      end
      if (found) begin
        used_map[res.page] = 1'b1;
        res.used = 1'b1;
      end else begin
        res.status = ST_NO_FREE;
      end
    end else if (req.page >= limit || (req.op == OP_FREE && req.page == 0)) begin
      res.status = ST_RANGE;
    end else if (req.op == OP_FREE) begin
      used_map[req.page] = 1'b0;
      last_freed = req.page;
    end else if (req.op == OP_RESERVE) begin
      used_map[req.page] = 1'b1;
      res.used = 1'b1;
    end else begin
      res.used = used_map[req.page];
    end
    return res;
  endfunction

  // page choice biased toward the allocation front and the page limit
  function automatic logic [11:0] pick_page(int total, int rsv);
    int limit;
    int roll;
    int p;
    limit = (total < MAP_PAGES) ? total : MAP_PAGES;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      p = $urandom_range(0, MAP_PAGES - 1);
    end else if (roll < 50) begin
      p = rsv + $urandom_range(0, 40);
    end else if (roll < 60) begin
      p = limit - 1 + $urandom_range(0, 2);
    end else begin
      p = $urandom_range(0, limit - 1);
    end
    if (p > MAP_PAGES - 1) p = MAP_PAGES - 1;
    return p[11:0];
  endfunction

  task automatic add_request(op_t op, logic [11:0] page);
    page_request_t req;
    req.op = op;
    req.page = page;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // random sequences: plain allocs, free then alloc, free/reserve/alloc, singles
  task automatic add_random_items(int total, int rsv, int count);
    int          made;
    int          roll;
    logic [11:0] pg;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      pg = pick_page(total, rsv);
      if (roll < 30) begin
        add_request(OP_ALLOC, 12'($urandom_range(0, MAP_PAGES - 1)));
        made += 1;
      end else if (roll < 45) begin
        add_request(OP_FREE, pg);
        add_request(OP_ALLOC, 12'($urandom_range(0, MAP_PAGES - 1)));
        made += 2;
      end else if (roll < 55) begin
        add_request(OP_FREE, pg);
        add_request(OP_RESERVE, pg);
        add_request(OP_ALLOC, 12'($urandom_range(0, MAP_PAGES - 1)));
        made += 3;
      end else if (roll < 70) begin
        add_request(OP_FREE, pg);
        made += 1;
      end else if (roll < 80) begin
        add_request(OP_RESERVE, pg);
        made += 1;
      end else begin
        add_request(OP_QUERY, pg);
        made += 1;
      end
    end
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every queued request is taken and answered
  task automatic wait_drained();
    @(negedge clk);
    while (requests_taken != requests_queued || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_req = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, drive_req.page, drive_req.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: config and request transfers feed the predictor, results are checked
  always @(posedge clk) begin
    if (rst) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      last_freed = '0;
      total_pages_reg = int'(TOTAL_PAGES_RST);
      reserved_below_reg = int'(RESERVED_BELOW_RST);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_PAGES: begin
            total_pages_reg = int'(cfg_data);
          end
          REG_RESERVED_BELOW: begin
            reserved_below_reg = int'(cfg_data);
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(
          predict_page_op(page_request_t'({s_tdata[1:0], s_tdata[13:2]})));
        req_taken = 1'b1;
        requests_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, got %h", $time, m_tdata);
          error_count++;
        end else begin
          want_result = expected_results.pop_front();
          if (m_tdata[11:0] !== want_result.page) begin
            $display("%0t: result_page expected %0d got %0d",
                     $time, want_result.page, m_tdata[11:0]);
            error_count++;
          end
          if (m_tdata[12] !== want_result.used) begin
            $display("%0t: page_used expected %0b got %0b",
                     $time, want_result.used, m_tdata[12]);
            error_count++;
          end
          if (m_tdata[14:13] !== want_result.status) begin
            $display("%0t: status expected %0d got %0d",
                     $time, want_result.status, m_tdata[14:13]);
            error_count++;
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_TOTAL_PAGES;
    cfg_data = '0;
    req_taken = 1'b0;
    requests_queued = 0;
    requests_taken = 0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: eight pages, allocation from page 4
    write_config(REG_TOTAL_PAGES, 13'd8);
    write_config(REG_RESERVED_BELOW, 13'd4);
    add_request(OP_QUERY, 12'd0);
    add_request(OP_RESERVE, 12'd0);
    add_request(OP_FREE, 12'd0);        // null page is ignored
    add_request(OP_ALLOC, 12'hABC);
    add_request(OP_ALLOC, 12'd0);
    add_request(OP_RESERVE, 12'd6);
    add_request(OP_ALLOC, 12'd0);
    add_request(OP_ALLOC, 12'hFFF);     // range exhausted
    add_request(OP_FREE, 12'd5);
    add_request(OP_FREE, 12'd5);        // freeing a free page
    add_request(OP_ALLOC, 12'd0);       // taken from the hint
    add_request(OP_FREE, 12'd6);
    add_request(OP_RESERVE, 12'd6);
    add_request(OP_ALLOC, 12'd0);       // stale hint, scan finds nothing
    add_request(OP_FREE, 12'd7);
    add_request(OP_FREE, 12'd4);
    add_request(OP_ALLOC, 12'd0);
    add_request(OP_ALLOC, 12'd0);       // hint was cleared, scan again
    add_request(OP_FREE, 12'd8);        // at the page limit
    add_request(OP_RESERVE, 12'd8);
    add_request(OP_QUERY, 12'hFFF);
    add_request(OP_QUERY, 12'd3);
    add_request(OP_FREE, 12'd2);        // below reserved_below, still a valid hint
    add_request(OP_ALLOC, 12'd0);
    add_request(OP_QUERY, 12'd2);
    wait_drained();

    // random phases over register settings, idle and stall patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_config(REG_TOTAL_PAGES, CFG_W'(phase_total[ph]));
      write_config(REG_RESERVED_BELOW, CFG_W'(phase_reserved[ph]));
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      add_random_items(phase_total[ph], phase_reserved[ph], phase_items[ph]);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
